// File: hw/rtl/dsd_pkg.sv
package dsd_pkg;

   localparam int OUT_W  = 16;
   localparam int FRAC_W = 16;
   localparam int IOR_W  = 15;

   localparam logic [IOR_W-1:0] IOR_RESET = 15'd6144;
   localparam logic [IOR_W-1:0] IOR_MIN   = 15'd4096;

endpackage

// File: hw/rtl/dsd_req_if.sv
interface dsd_req_if import dsd_pkg::*; #(
   parameter int COMPONENT_WIDTH = 16
) ();

   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] dir_x;
   logic signed [COMPONENT_WIDTH-1:0] dir_y;
   logic signed [COMPONENT_WIDTH-1:0] dir_z;
   logic signed [COMPONENT_WIDTH-1:0] normal_x;
   logic signed [COMPONENT_WIDTH-1:0] normal_y;
   logic signed [COMPONENT_WIDTH-1:0] normal_z;
   logic                              outer_hit;
   logic        [FRAC_W-1:0]          random_fraction;

   modport source (
      output valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
             outer_hit, random_fraction,
      input  ready
   );

   modport sink (
      input  valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
             outer_hit, random_fraction,
      output ready
   );

endinterface

// File: hw/rtl/dsd_rsp_if.sv
interface dsd_rsp_if import dsd_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] out_x;
   logic signed [OUT_W-1:0] out_y;
   logic signed [OUT_W-1:0] out_z;
   logic                    was_reflected;
   logic                    total_internal;
   logic                    invalid_input;

   modport source (
      output valid, out_x, out_y, out_z, was_reflected, total_internal, invalid_input,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, was_reflected, total_internal, invalid_input,
      output ready
   );

endinterface

// File: hw/rtl/dielectric_scatter_direction.sv
// Dielectric scatter direction: takes one ray item per clock while the pipeline is not frozen
// and presents its reflected or refracted Q1.14 direction (zero for a zero input direction)
// after 79 register stages, one result item per input item. The stage count is set by the
// 31-step square root that normalizes the direction, the 16-step divider that forms the unit
// vector and the 15-step square root of the refraction term, all unrolled into register
// stages. When a finished result waits on the result side, the whole pipeline freezes; the
// refraction index register is sampled as each item enters.
module dielectric_scatter_direction import dsd_pkg::*; #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [IOR_W-1:0]  csr_wr_data,
   dsd_req_if.sink           req_if,
   dsd_rsp_if.source         rsp_if
);

   localparam int CW = COMPONENT_WIDTH;
   localparam int BW = $clog2(CW + 1);

   localparam int S_IN    = 0;
   localparam int S_ABS   = 1;
   localparam int S_MAX   = 2;
   localparam int EDIV0   = 2;
   localparam int S_SHIFT = 3;
   localparam int S_SQ    = 4;
   localparam int S_SUM   = 5;
   localparam int LSQ0    = 6;
   localparam int S_EPICK = 19;
   localparam int S_E2    = 20;
   localparam int RDIV0   = 20;
   localparam int S_R0    = 37;
   localparam int S_UINIT = 37;
   localparam int UDIV0   = 38;
   localparam int S_USGN  = 54;
   localparam int S_DOT   = 55;
   localparam int S_COS   = 56;
   localparam int S_C2    = 57;
   localparam int S_P0    = 58;
   localparam int PSTEP0  = 58;
   localparam int S_P1    = 59;
   localparam int S_K     = 60;
   localparam int KSQ0    = 61;
   localparam int S_RFP   = 62;
   localparam int S_RFL   = 63;
   localparam int S_COEF  = 76;
   localparam int S_CN    = 77;
   localparam int S_OUT   = 78;
   localparam int NST     = 79;

   typedef struct packed {
      logic [2:0][CW-1:0] d;
      logic [2:0][15:0]   n;
      logic               ff;
      logic [FRAC_W-1:0]  rnd;
      logic [IOR_W-1:0]   ir;
      logic               zero;
      logic [2:0][CW-1:0] a;
      logic [BW-1:0]      bl;
      logic [2:0][15:0]   an;
      logic [2:0][31:0]   sq;
      logic [61:0]        xs;
      logic [32:0]        lrem;
      logic [30:0]        lroot;
      logic [2:0][46:0]   urem;
      logic [2:0][15:0]   uq;
      logic [2:0][16:0]   u;
      logic [2:0][32:0]   un;
      logic [2:0][37:0]   eu;
      logic [15:0]        cosv;
      logic [28:0]        c2;
      logic [15:0]        xv;
      logic [19:0]        pp;
      logic [2:0][30:0]   cn;
      logic [36:0]        ec;
      logic [31:0]        erem;
      logic [16:0]        eq;
      logic [19:0]        eta;
      logic [35:0]        e2;
      logic [36:0]        rrem;
      logic [19:0]        rden;
      logic [16:0]        rq;
      logic [16:0]        r0;
      logic [46:0]        pl;
      logic [46:0]        ph;
      logic [65:0]        prod;
      logic               tir;
      logic [29:0]        kx;
      logic [16:0]        krem;
      logic [14:0]        kroot;
      logic [38:0]        rfp;
      logic [23:0]        rfl;
      logic               rsel;
      logic [23:0]        coef;
      logic [2:0][39:0]   coefn;
      logic [2:0][15:0]   ox;
      logic               wr;
      logic               ti;
      logic               inv;
   } item_type;

   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned sh);
      logic [63:0] mag;
      mag = v[63] ? unsigned'(-v) : unsigned'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -signed'(mag) : signed'(mag);
   endfunction

   function automatic logic [15:0] sat_q14(input logic signed [63:0] v);
      logic signed [63:0] lim;
      lim = 64'sd16384;
      if (v > lim) begin
         return 16'h4000;
      end else if (v < -lim) begin
         return 16'hC000;
      end
      return v[15:0];
   endfunction

   function automatic logic [BW-1:0] bit_len(input logic [CW-1:0] m);
      logic [BW-1:0] r;
      r = '0;
      for (int i = 0; i < CW; i++) begin
         if (m[i]) begin
            r = BW'(i + 1);
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] sat_normal(input logic signed [CW-1:0] v);
      logic signed [32:0] e;
      e = 33'(v);
      if (e > 33'sd16384) begin
         return 16'h4000;
      end else if (e < -33'sd16384) begin
         return 16'hC000;
      end
      return e[15:0];
   endfunction

   logic [IOR_W-1:0] ior_ff;
   logic [IOR_W-1:0] ior_in;
   logic [NST-1:0]   vld_ff;
   logic [NST-1:0]   vld_in;
   item_type         pipe_ff [NST];
   item_type         pipe_in [NST];
   item_type         head;
   logic             ce;

   assign ior_in = csr_wr_en ? csr_wr_data : ior_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ior_ff <= IOR_RESET;
      end else begin
         ior_ff <= ior_in;
      end
   end

   assign ce           = !vld_ff[NST-1] || rsp_if.ready;
   assign req_if.ready = ce;
   assign vld_in       = {vld_ff[NST-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      head      = '0;
      head.d[0] = req_if.dir_x;
      head.d[1] = req_if.dir_y;
      head.d[2] = req_if.dir_z;
      head.n[0] = sat_normal(req_if.normal_x);
      head.n[1] = sat_normal(req_if.normal_y);
      head.n[2] = sat_normal(req_if.normal_z);
      head.ff   = req_if.outer_hit;
      head.rnd  = req_if.random_fraction;
      head.ir   = (ior_ff < IOR_MIN) ? IOR_MIN : ior_ff;
   end

   for (genvar s = 0; s < NST; s++) begin : g_stage
      localparam int ET = s - EDIV0;
      localparam int EJ = (ET >= 0 && ET < 17) ? 16 - ET : 0;
      localparam int LT = s - LSQ0;
      localparam int LJ = (LT >= 0 && LT < 31) ? 30 - LT : 0;
      localparam int RT = s - RDIV0;
      localparam int RJ = (RT >= 0 && RT < 17) ? 16 - RT : 0;
      localparam int UT = s - UDIV0;
      localparam int UJ = (UT >= 0 && UT < 16) ? 15 - UT : 0;
      localparam int KT = s - KSQ0;
      localparam int KJ = (KT >= 0 && KT < 15) ? 14 - KT : 0;

      item_type src;
      assign src = (s == S_IN) ? head : pipe_ff[(s == 0) ? 0 : s - 1];

      always_comb begin : p_next
         item_type           nx;
         logic [CW-1:0]      mx;
         logic [CW+15:0]     shv;
         logic [33:0]        ssum;
         logic [32:0]        lsh;
         logic [32:0]        ltr;
         logic [16:0]        ksh;
         logic [16:0]        ktr;
         logic [31:0]        edv;
         logic [36:0]        rdv;
         logic [46:0]        udv;
         logic [19:0]        rnum;
         logic signed [63:0] acc;
         logic signed [63:0] orl;
         logic signed [63:0] orr;
         logic signed [31:0] csq;
         logic [35:0]        pmul;
         logic [28:0]        s2;
         logic [65:0]        kk;

         nx   = src;
         mx   = '0;
         shv  = '0;
         ssum = '0;
         lsh  = '0;
         ltr  = '0;
         ksh  = '0;
         ktr  = '0;
         edv  = '0;
         rdv  = '0;
         udv  = '0;
         rnum = '0;
         acc  = '0;
         orl  = '0;
         orr  = '0;
         csq  = '0;
         pmul = '0;
         s2   = '0;
         kk   = '0;

         if (s == S_ABS) begin
            for (int i = 0; i < 3; i++) begin
               nx.a[i] = nx.d[i][CW-1] ? (~nx.d[i] + 1'b1) : nx.d[i];
            end
            nx.zero = (nx.d == '0);
            nx.erem = 32'(29'h1000_0000) + 32'(nx.ir >> 1);
            nx.eq   = '0;
         end

         if (s == S_MAX) begin
            mx = nx.a[0];
            if (nx.a[1] > mx) begin
               mx = nx.a[1];
            end
            if (nx.a[2] > mx) begin
               mx = nx.a[2];
            end
            nx.bl = bit_len(mx);
         end

         if (ET >= 0 && ET < 17) begin
            edv = 32'(nx.ir) << EJ;
            if (nx.erem >= edv) begin
               nx.erem   = nx.erem - edv;
               nx.eq[EJ] = 1'b1;
            end
         end

         if (s == S_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
               shv      = {nx.a[i], 16'b0} >> nx.bl;
               nx.an[i] = shv[15:0];
            end
         end

         if (s == S_SQ) begin
            for (int i = 0; i < 3; i++) begin
               nx.sq[i] = {16'b0, nx.an[i]} * {16'b0, nx.an[i]};
            end
         end

         if (s == S_SUM) begin
            ssum     = 34'(nx.sq[0]) + 34'(nx.sq[1]) + 34'(nx.sq[2]);
            nx.xs    = {ssum, 28'b0};
            nx.lrem  = '0;
            nx.lroot = '0;
         end

         if (LT >= 0 && LT < 31) begin
            lsh = {nx.lrem[30:0], nx.xs[2*LJ+1 -: 2]};
            ltr = {nx.lroot, 2'b01};
            if (lsh >= ltr) begin
               nx.lrem  = lsh - ltr;
               nx.lroot = {nx.lroot[29:0], 1'b1};
            end else begin
               nx.lrem  = lsh;
               nx.lroot = {nx.lroot[29:0], 1'b0};
            end
         end

         if (s == S_EPICK) begin
            nx.eta  = nx.ff ? 20'(nx.eq) : 20'({nx.ir, 4'b0});
            rnum    = (nx.eta > 20'd65536) ? (nx.eta - 20'd65536) : (20'd65536 - nx.eta);
            nx.rden = 20'd65536 + nx.eta;
            nx.rrem = 37'({rnum, 16'b0}) + 37'(nx.rden >> 1);
            nx.rq   = '0;
         end

         if (s == S_E2) begin
            nx.e2 = 36'(({20'b0, nx.eta} * {20'b0, nx.eta} + 40'd8) >> 4);
         end

         if (RT >= 0 && RT < 17) begin
            rdv = 37'(nx.rden) << RJ;
            if (nx.rrem >= rdv) begin
               nx.rrem   = nx.rrem - rdv;
               nx.rq[RJ] = 1'b1;
            end
         end

         if (s == S_R0) begin
            nx.r0 = 17'(({17'b0, nx.rq} * {17'b0, nx.rq} + 34'd32768) >> 16);
         end

         if (s == S_UINIT) begin
            for (int i = 0; i < 3; i++) begin
               nx.urem[i] = 47'({nx.an[i], 28'b0}) + 47'(nx.lroot >> 1);
            end
            nx.uq = '0;
         end

         if (UT >= 0 && UT < 16) begin
            udv = 47'(nx.lroot) << UJ;
            for (int i = 0; i < 3; i++) begin
               if (nx.urem[i] >= udv) begin
                  nx.urem[i]   = nx.urem[i] - udv;
                  nx.uq[i][UJ] = 1'b1;
               end
            end
         end

         if (s == S_USGN) begin
            for (int i = 0; i < 3; i++) begin
               nx.u[i] = nx.d[i][CW-1] ? (~{1'b0, nx.uq[i]} + 17'd1) : {1'b0, nx.uq[i]};
            end
         end

         if (s == S_DOT) begin
            for (int i = 0; i < 3; i++) begin
               nx.un[i] = $signed({{16{nx.u[i][16]}}, nx.u[i]})
                        * $signed({{17{nx.n[i][15]}}, nx.n[i]});
               nx.eu[i] = $signed({18'b0, nx.eta})
                        * $signed({{21{nx.u[i][16]}}, nx.u[i]});
            end
         end

         if (s == S_COS) begin
            acc     = 64'($signed(nx.un[0])) + 64'($signed(nx.un[1]))
                    + 64'($signed(nx.un[2]));
            nx.cosv = sat_q14(-rnd_shift(acc, 14));
         end

         if (s == S_C2) begin
            csq   = $signed({{16{nx.cosv[15]}}, nx.cosv})
                  * $signed({{16{nx.cosv[15]}}, nx.cosv});
            nx.c2 = csq[28:0];
            nx.xv = 16'h4000 - nx.cosv;
            nx.pp = 20'(nx.xv);
            for (int i = 0; i < 3; i++) begin
               nx.cn[i] = $signed({{15{nx.cosv[15]}}, nx.cosv})
                        * $signed({{15{nx.n[i][15]}}, nx.n[i]});
            end
            nx.ec = $signed({17'b0, nx.eta}) * $signed({{21{nx.cosv[15]}}, nx.cosv});
         end

         if (s >= PSTEP0 && s < PSTEP0 + 4) begin
            pmul  = {16'b0, nx.pp} * {20'b0, nx.xv};
            nx.pp = 20'((pmul + 36'd8192) >> 14);
         end

         if (s == S_P0) begin
            s2    = 29'h1000_0000 - nx.c2;
            nx.pl = {29'b0, nx.e2[17:0]} * {18'b0, s2};
            nx.ph = {29'b0, nx.e2[35:18]} * {18'b0, s2};
         end

         if (s == S_P1) begin
            nx.prod = 66'({nx.ph, 18'b0}) + 66'(nx.pl);
         end

         if (s == S_K) begin
            nx.tir   = nx.prod > (66'd1 << 56);
            kk       = 66'h1000_0000 - ((nx.prod + 66'h800_0000) >> 28);
            nx.kx    = {1'b0, kk[28:0]};
            nx.krem  = '0;
            nx.kroot = '0;
         end

         if (KT >= 0 && KT < 15) begin
            ksh = {nx.krem[14:0], nx.kx[2*KJ+1 -: 2]};
            ktr = {nx.kroot, 2'b01};
            if (ksh >= ktr) begin
               nx.krem  = ksh - ktr;
               nx.kroot = {nx.kroot[13:0], 1'b1};
            end else begin
               nx.krem  = ksh;
               nx.kroot = {nx.kroot[13:0], 1'b0};
            end
         end

         if (s == S_RFP) begin
            nx.rfp = {22'b0, 17'h10000 - nx.r0} * {17'b0, nx.pp, 2'b00};
         end

         if (s == S_RFL) begin
            nx.rfl  = 24'(nx.r0) + 24'((nx.rfp + 39'd32768) >> 16);
            nx.rsel = nx.tir || (nx.rfl > 24'(nx.rnd));
         end

         if (s == S_COEF) begin
            acc     = 64'(nx.kroot) - rnd_shift(64'($signed(nx.ec)), 16);
            nx.coef = acc[23:0];
         end

         if (s == S_CN) begin
            for (int i = 0; i < 3; i++) begin
               nx.coefn[i] = $signed({{16{nx.coef[23]}}, nx.coef})
                           * $signed({{24{nx.n[i][15]}}, nx.n[i]});
            end
         end

         if (s == S_OUT) begin
            for (int i = 0; i < 3; i++) begin
               orl = 64'($signed(nx.u[i]))
                   + rnd_shift(64'($signed(nx.cn[i])) <<< 1, 14);
               orr = rnd_shift(64'($signed(nx.eu[i])), 16)
                   - rnd_shift(64'($signed(nx.coefn[i])), 14);
               nx.ox[i] = nx.zero ? 16'b0 : sat_q14(nx.rsel ? orl : orr);
            end
            nx.wr  = !nx.zero && nx.rsel;
            nx.ti  = !nx.zero && nx.tir;
            nx.inv = nx.zero;
         end

         pipe_in[s] = nx;
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   assign rsp_if.valid          = vld_ff[NST-1];
   assign rsp_if.out_x          = pipe_ff[NST-1].ox[0];
   assign rsp_if.out_y          = pipe_ff[NST-1].ox[1];
   assign rsp_if.out_z          = pipe_ff[NST-1].ox[2];
   assign rsp_if.was_reflected  = pipe_ff[NST-1].wr;
   assign rsp_if.total_internal = pipe_ff[NST-1].ti;
   assign rsp_if.invalid_input  = pipe_ff[NST-1].inv;

endmodule

// File: verif/dsd_scatter_checker.sv
module dsd_scatter_checker import dsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IOR_W-1:0] csr_wr_data,
   dsd_req_if               req,
   dsd_rsp_if               rsp,
   output int               errors,
   output int               pending,
   output int               rays_seen,
   output int               reflected_seen,
   output int               tir_seen,
   output int               zero_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE = 16384;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic                    refl;
      logic                    tir;
      logic                    bad;
   } scatter_type;

   scatter_type      expected_dirs[$];
   logic [IOR_W-1:0] ior_now;

   function automatic longint clip(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic longint round_shift(longint v, int s);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, bits;
      r = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= r + bits) begin
            v = v - (r + bits);
            r = (r >> 1) + bits;
         end else begin
            r = r >> 1;
         end
         bits = bits >> 2;
      end
      return r;
   endfunction

   function automatic scatter_type scatter_ray(longint d[3], longint nraw[3], logic ff,
                                               logic [FRAC_W-1:0] rnd,
                                               logic [IOR_W-1:0] ior);
      longint nv[3], uv[3], ov[3];
      longint unsigned a[3];
      longint unsigned mx, sum, len, q, irv, eta, c2, s2, e2, prod;
      longint unsigned num, den, r0f, r0, x, p, refl, k;
      longint dot, cosv, sk, coef;
      int b;
      logic tir, reflect;
      scatter_type res;
      res = '0;
      for (int i = 0; i < 3; i++) nv[i] = clip(nraw[i]);
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
         res.bad = 1'b1;
         return res;
      end
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = (d[i] < 0) ? -d[i] : d[i];
         if (a[i] > mx) mx = a[i];
      end
      b = 0;
      while ((mx >> b) != 0) b++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (b > 16) a[i] = a[i] >> (b - 16);
         else a[i] = a[i] << (16 - b);
         sum += a[i] * a[i];
      end
      len = root_floor(sum << 28);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         q = ((a[i] << 28) + (len >> 1)) / len;
         uv[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
         dot += uv[i] * nv[i];
      end
      cosv = clip(-round_shift(dot, 14));
      irv = (ior < IOR_MIN) ? 64'(IOR_MIN) : 64'(ior);
      eta = ff ? (((64'd1 << 28) + (irv >> 1)) / irv) : (irv << 4);
      c2 = longint'(cosv * cosv);
      s2 = (64'd1 << 28) - c2;
      e2 = (eta * eta + 64'd8) >> 4;
      prod = e2 * s2;
      tir = prod > (64'd1 << 56);
      num = (eta > 64'd65536) ? eta - 64'd65536 : 64'd65536 - eta;
      den = 64'd65536 + eta;
      r0f = ((num << 16) + (den >> 1)) / den;
      r0 = (r0f * r0f + 64'd32768) >> 16;
      x = longint'(ONE - cosv);
      p = x;
      for (int i = 0; i < 4; i++) p = (p * x + 64'd8192) >> 14;
      refl = r0 + (((64'd65536 - r0) * (p << 2) + 64'd32768) >> 16);
      reflect = tir || (refl > 64'(rnd));
      if (reflect) begin
         for (int i = 0; i < 3; i++) ov[i] = uv[i] + round_shift(2 * cosv * nv[i], 14);
      end else begin
         k = (64'd1 << 28) - ((prod + (64'd1 << 27)) >> 28);
         sk = longint'(root_floor(k));
         coef = sk - round_shift(longint'(eta) * cosv, 16);
         for (int i = 0; i < 3; i++)
            ov[i] = round_shift(longint'(eta) * uv[i], 16) - round_shift(coef * nv[i], 14);
      end
      res.x = OUT_W'(clip(ov[0]));
      res.y = OUT_W'(clip(ov[1]));
      res.z = OUT_W'(clip(ov[2]));
      res.refl = reflect;
      res.tir = tir;
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   initial begin
      errors = 0;
      rays_seen = 0;
      reflected_seen = 0;
      tir_seen = 0;
      zero_seen = 0;
      ior_now = IOR_RESET;
   end

   assign pending = expected_dirs.size();

   always @(posedge clock) begin
      longint d[3], n[3];
      scatter_type want;
      if (reset) begin
         ior_now <= IOR_RESET;
      end else begin
         if (csr_wr_en) ior_now <= csr_wr_data;
         if (req.valid && req.ready) begin
            d[0] = req.dir_x;
            d[1] = req.dir_y;
            d[2] = req.dir_z;
            n[0] = req.normal_x;
            n[1] = req.normal_y;
            n[2] = req.normal_z;
            want = scatter_ray(d, n, req.outer_hit, req.random_fraction, ior_now);
            expected_dirs.push_back(want);
            rays_seen++;
            reflected_seen += want.refl;
            tir_seen += want.tir;
            zero_seen += want.bad;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_dirs.size() == 0) begin
               $display("%0t result item with no ray waiting", $realtime);
               errors++;
            end else begin
               want = expected_dirs.pop_front();
               if (rsp.out_x !== want.x) report_mismatch("out_x", rsp.out_x, want.x);
               if (rsp.out_y !== want.y) report_mismatch("out_y", rsp.out_y, want.y);
               if (rsp.out_z !== want.z) report_mismatch("out_z", rsp.out_z, want.z);
               if (rsp.was_reflected !== want.refl)
                  report_mismatch("was_reflected", rsp.was_reflected, want.refl);
               if (rsp.total_internal !== want.tir)
                  report_mismatch("total_internal", rsp.total_internal, want.tir);
               if (rsp.invalid_input !== want.bad)
                  report_mismatch("invalid_input", rsp.invalid_input, want.bad);
            end
         end
      end
   end

endmodule

// File: verif/tb_dielectric_scatter_direction.sv
module tb_dielectric_scatter_direction;
   import dsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [IOR_W-1:0] csr_wr_data;
   int               errors, pending, rays_seen, reflected_seen, tir_seen, zero_seen;
   int               settings;
   bit               quiet;

   dsd_req_if #(.COMPONENT_WIDTH(16)) req_if ();
   dsd_rsp_if rsp_if ();

   dielectric_scatter_direction #(.COMPONENT_WIDTH(16)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   dsd_scatter_checker chk (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req            (req_if),
      .rsp            (rsp_if),
      .errors         (errors),
      .pending        (pending),
      .rays_seen      (rays_seen),
      .reflected_seen (reflected_seen),
      .tir_seen       (tir_seen),
      .zero_seen      (zero_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

   task automatic send_ray(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                           logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                           logic ff, logic [15:0] rf);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.dir_x           <= dx;
      req_if.dir_y           <= dy;
      req_if.dir_z           <= dz;
      req_if.normal_x        <= nx;
      req_if.normal_y        <= ny;
      req_if.normal_z        <= nz;
      req_if.outer_hit       <= ff;
      req_if.random_fraction <= rf;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_ior(logic [IOR_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings++;
   endtask

   task automatic random_ray();
      real fx, fy, fz, mag;
      int sh;
      logic [15:0] dx, dy, dz, nx, ny, nz;
      sh = $urandom_range(0, 15);
      dx = $signed(16'($urandom)) >>> sh;
      dy = $signed(16'($urandom)) >>> sh;
      dz = $signed(16'($urandom)) >>> sh;
      if ($urandom_range(0, 29) == 0) {dx, dy, dz} = '0;
      if ($urandom_range(0, 9) == 0) begin
         nx = 16'($urandom);
         ny = 16'($urandom);
         nz = 16'($urandom);
      end else begin
         do begin
            fx = real'(int'($urandom_range(0, 32768)) - 16384);
            fy = real'(int'($urandom_range(0, 32768)) - 16384);
            fz = real'(int'($urandom_range(0, 32768)) - 16384);
            mag = $sqrt(fx * fx + fy * fy + fz * fz);
         end while (mag < 1000.0);
         nx = 16'(int'(fx * 16384.0 / mag));
         ny = 16'(int'(fy * 16384.0 / mag));
         nz = 16'(int'(fz * 16384.0 / mag));
      end
      send_ray(dx, dy, dz, nx, ny, nz, 1'($urandom), 16'($urandom));
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int w;
         w = quiet ? 0 : $urandom_range(0, 19);
         if (w > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      logic [IOR_W-1:0] iors[7];
      settings = 0;
      quiet = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid <= 1'b0;
      req_if.dir_x <= '0;
      req_if.dir_y <= '0;
      req_if.dir_z <= '0;
      req_if.normal_x <= '0;
      req_if.normal_y <= '0;
      req_if.normal_z <= '0;
      req_if.outer_hit <= 1'b0;
      req_if.random_fraction <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rays at the reset index
      send_ray(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b1, 16'd0);
      send_ray(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd16384, 1'b1, 16'hFFFF);
      send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hC000, 16'd0, 16'd0, 1'b0, 16'd0);
      send_ray(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b1, 16'hFFFF);
      send_ray(16'd0, 16'hC000, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b1, 16'd0);
      send_ray(16'd1, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b1, 16'h8000);
      send_ray(16'd100, 16'hFFF0, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0, 16'hFFFF);
      send_ray(16'd8000, 16'hFF00, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0, 16'hFFFF);
      send_ray(16'd0, 16'h8000, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 16'h1234);
      send_ray(16'd0, 16'h8000, 16'd0, 16'd0, 16'h8000, 16'd0, 1'b1, 16'hFFFF);
      send_ray(16'd3000, 16'h8000, 16'd200, 16'd9000, 16'd9000, 16'd9000, 1'b0, 16'hFFFF);
      send_ray(16'h7FFF, 16'd0, 16'd0, 16'h8001, 16'd0, 16'd0, 1'b1, 16'hFFFF);

      set_ior(15'd4096);
      send_ray(16'd50, 16'hFF00, 16'd7, 16'd0, 16'd16384, 16'd0, 1'b1, 16'd0);
      send_ray(16'd50, 16'hFF00, 16'd7, 16'd0, 16'd16384, 16'd0, 1'b0, 16'hFFFF);
      set_ior(15'd32767);
      send_ray(16'd50, 16'hFF00, 16'd7, 16'd0, 16'd16384, 16'd0, 1'b1, 16'hFFFF);
      send_ray(16'd50, 16'hFF00, 16'd7, 16'd0, 16'd16384, 16'd0, 1'b0, 16'd0);
      send_ray(16'd0, 16'hFF00, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0, 16'hFFFF);
      set_ior(15'd0);
      send_ray(16'd50, 16'hFF00, 16'd7, 16'd0, 16'd16384, 16'd0, 1'b1, 16'hFFFF);
      send_ray(16'd50, 16'hFF00, 16'd7, 16'd0, 16'd16384, 16'd0, 1'b0, 16'hFFFF);

      iors[0] = 15'd6144;
      iors[1] = 15'd4096;
      iors[2] = 15'd32767;
      iors[3] = 15'($urandom_range(0, 4095));
      iors[4] = 15'($urandom_range(4096, 32767));
      iors[5] = 15'($urandom_range(4096, 8192));
      iors[6] = 15'd5461;
      foreach (iors[s]) begin
         set_ior(iors[s]);
         for (int i = 0; i < 93; i++) begin
            if (i % 31 == 0) quiet = ($urandom_range(0, 3) == 0);
            random_ray();
         end
         quiet = 0;
      end

      drain();
      $display("Ran %0d rays under %0d index settings plus the reset value.", rays_seen,
               settings);
      $display("Of these %0d reflected, %0d by total internal reflection, %0d zero directions.",
               reflected_seen, tir_seen, zero_seen);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/dsd_pkg.sv
hw/rtl/dsd_req_if.sv
hw/rtl/dsd_rsp_if.sv
hw/rtl/dielectric_scatter_direction.sv
verif/dsd_scatter_checker.sv
verif/tb_dielectric_scatter_direction.sv
